@@ hw/rtl/cpba_pkg.sv @@
// Package for the first-fit page allocator: field widths, command and
// status codes, the request and response structs and default parameters.
// Depends on nothing.
package cpba_pkg;

    localparam int SIZE_W = 19;
    localparam int PAGE_W = 6;

    localparam int PAGES_DEF = 64;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [PAGE_W-1:0] start_page;
    } cpba_req_t;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] first_page;
    } cpba_rsp_t;

endpackage

@@ hw/rtl/cpba_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module cpba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/cpba_front.sv @@
// Front end of the allocator: takes a command, divides the byte size by the
// page size with a reciprocal multiply and classifies the job for the queue.
// Depends on cpba_pkg.
module cpba_front #(
    parameter int PAGES = cpba_pkg::PAGES_DEF,
    parameter int PAGE_BYTES = cpba_pkg::PAGE_BYTES_DEF,
    parameter int CNT_W = $clog2(PAGES + 1),
    parameter int JOB_W = 2 + cpba_pkg::PAGE_W + CNT_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cpba_pkg::cpba_req_t req,
    output logic                push,
    output logic [JOB_W-1:0]    job,
    input  logic                full
);
    import cpba_pkg::*;

    localparam int EW = SIZE_W + 1;
    localparam int RW = SIZE_W + 2;
    localparam int PROD_W = SIZE_W + RW;
    localparam int SHIFT = SIZE_W + $clog2(PAGE_BYTES);
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(PAGE_BYTES) - 1)
        / longint'(PAGE_BYTES);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
    localparam logic [SIZE_W-1:0] PAGE_S = SIZE_W'(PAGE_BYTES);
    localparam logic [EW-1:0] PAGES_E = EW'(PAGES);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV = 2'd1;
    localparam logic [1:0] F_REM = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    typedef struct packed {
        logic              fail;
        logic              cmd;
        logic [PAGE_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } job_t;

    logic [1:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] quo_reg, quo_next;
    logic              frac_reg, frac_next;
    logic              cmd_reg, cmd_next;
    logic              zero_reg, zero_next;
    logic [PAGE_W-1:0] start_reg, start_next;

    logic [PROD_W-1:0] prod;
    logic [SIZE_W-1:0] rem_low;
    logic [EW-1:0]     need;
    logic [EW-1:0]     free_end;
    logic              alloc_fail;
    logic              free_fail;
    job_t              job_w;

    // The rounded-up reciprocal gives the exact quotient for every size in the field.
    assign prod = PROD_W'(size_reg) * PROD_W'(RECIP);
    assign rem_low = size_reg - quo_reg * PAGE_S;
    assign need = {1'b0, quo_reg} + EW'(frac_reg);
    assign free_end = {1'b0, quo_reg} + EW'(start_reg);
    assign alloc_fail = zero_reg || (need > PAGES_E);
    assign free_fail = zero_reg || frac_reg || (free_end > PAGES_E);

    always_comb
    begin
        job_w.cmd = cmd_reg;
        job_w.start = start_reg;
        if (cmd_reg == CMD_ALLOC)
        begin
            job_w.fail = alloc_fail;
            job_w.count = alloc_fail ? '0 : CNT_W'(need);
        end
        else
        begin
            job_w.fail = free_fail;
            job_w.count = free_fail ? '0 : CNT_W'(quo_reg);
        end
    end

    assign job = job_w;
    assign busy = (state_reg != F_IDLE);
    assign push = (state_reg == F_PUSH) && !full;

    always_comb
    begin
        state_next = state_reg;
        size_next = size_reg;
        quo_next = quo_reg;
        frac_next = frac_reg;
        cmd_next = cmd_reg;
        zero_next = zero_reg;
        start_next = start_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    size_next = req.size_bytes;
                    cmd_next = req.cmd;
                    zero_next = (req.size_bytes == '0);
                    start_next = req.start_page;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                quo_next = SIZE_W'(prod >> SHIFT);
                state_next = F_REM;
            end
            F_REM:
            begin
                frac_next = (rem_low != '0);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        quo_reg <= quo_next;
        frac_reg <= frac_next;
        cmd_reg <= cmd_next;
        zero_reg <= zero_next;
        start_reg <= start_next;
    end

endmodule

@@ hw/rtl/cpba_queue.sv @@
// Short first-in first-out queue of classified jobs between front and back.
// Depends on nothing.
module cpba_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Job pushed into a full queue.");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Job popped from an empty queue.");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("Queue fill count is above its depth.");

endmodule

@@ hw/rtl/cpba_back.sv @@
// Back end of the allocator: clears the busy map after reset, scans it for
// the first free run, marks or clears runs and drives the result strobe.
// Depends on cpba_pkg and cpba_ram.
module cpba_back #(
    parameter int PAGES = cpba_pkg::PAGES_DEF,
    parameter int CNT_W = $clog2(PAGES + 1),
    parameter int JOB_W = 2 + cpba_pkg::PAGE_W + CNT_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [JOB_W-1:0]    job,
    input  logic                empty,
    output logic                pop,
    output logic                clearing,
    output logic                done,
    output cpba_pkg::cpba_rsp_t rsp
);
    import cpba_pkg::*;

    localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic [AW-1:0] LAST = AW'(PAGES - 1);
    localparam logic [AW:0] PAGES_A = (AW + 1)'(PAGES);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE = 2'd1;
    localparam logic [1:0] B_SCAN = 2'd2;
    localparam logic [1:0] B_WRITE = 2'd3;

    typedef struct packed {
        logic              fail;
        logic              cmd;
        logic [PAGE_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } job_t;

    job_t             head;
    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    p_reg, p_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [AW:0]      a_reg, a_next;
    logic             dv_reg, dv_next;
    logic [AW-1:0]    c_reg, c_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic             wv_reg, wv_next;
    logic [PAGE_W-1:0] first_reg, first_next;
    logic             done_reg, done_next;
    cpba_rsp_t        rsp_reg, rsp_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic             ram_rdata;
    logic [AW-1:0]    start_calc;

    assign head = job;
    assign start_calc = c_reg - AW'(need_reg - CNT_W'(1));
    assign clearing = (state_reg == B_CLEAR);
    assign done = done_reg;
    assign rsp = rsp_reg;

    cpba_ram #(
        .WIDTH(1),
        .DEPTH(PAGES),
        .AW(AW)
    ) u_map (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        p_next = p_reg;
        n_next = n_reg;
        a_next = a_reg;
        dv_next = 1'b0;
        c_next = c_reg;
        run_next = run_reg;
        need_next = need_reg;
        wv_next = wv_reg;
        first_next = first_reg;
        done_next = 1'b0;
        rsp_next = rsp_reg;
        pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = p_reg;
        ram_wdata = wv_reg;
        ram_raddr = a_reg[AW-1:0];
        case (state_reg)
            B_CLEAR:
            begin
                ram_we = 1'b1;
                ram_wdata = 1'b0;
                p_next = p_reg + 1'b1;
                if (p_reg == LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    need_next = head.count;
                    if (head.fail)
                    begin
                        done_next = 1'b1;
                        rsp_next.status = STATUS_FAIL;
                        rsp_next.first_page = '0;
                    end
                    else if (head.cmd == CMD_ALLOC)
                    begin
                        a_next = '0;
                        run_next = '0;
                        state_next = B_SCAN;
                    end
                    else
                    begin
                        p_next = AW'(head.start);
                        n_next = head.count;
                        wv_next = 1'b0;
                        first_next = '0;
                        state_next = B_WRITE;
                    end
                end
            end
            B_SCAN:
            begin
                if (a_reg < PAGES_A)
                begin
                    a_next = a_reg + 1'b1;
                    dv_next = 1'b1;
                    c_next = a_reg[AW-1:0];
                end
                if (dv_reg)
                begin
                    run_next = ram_rdata ? '0 : run_reg + 1'b1;
                    if (!ram_rdata && (run_reg + 1'b1 == need_reg))
                    begin
                        dv_next = 1'b0;
                        p_next = start_calc;
                        n_next = need_reg;
                        wv_next = 1'b1;
                        first_next = PAGE_W'(start_calc);
                        state_next = B_WRITE;
                    end
                    else if (c_reg == LAST)
                    begin
                        dv_next = 1'b0;
                        done_next = 1'b1;
                        rsp_next.status = STATUS_FAIL;
                        rsp_next.first_page = '0;
                        state_next = B_IDLE;
                    end
                end
            end
            B_WRITE:
            begin
                ram_we = 1'b1;
                p_next = p_reg + 1'b1;
                n_next = n_reg - 1'b1;
                if (n_reg == CNT_W'(1))
                begin
                    done_next = 1'b1;
                    rsp_next.status = STATUS_OK;
                    rsp_next.first_page = first_reg;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            p_reg <= '0;
            n_reg <= '0;
            a_reg <= '0;
            dv_reg <= 1'b0;
            run_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg <= p_next;
            n_reg <= n_next;
            a_reg <= a_next;
            dv_reg <= dv_next;
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        need_reg <= need_next;
        wv_reg <= wv_next;
        first_reg <= first_next;
        rsp_reg <= rsp_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SCAN) |-> (run_reg < need_reg))
        else $error("Free run count reached the request without being taken.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WRITE) |-> (n_reg != '0))
        else $error("Run update entered with no pages left to write.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !done_reg && !pop)
        else $error("Result or job handled during the map clearing pass.");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (done_reg || (state_reg != B_IDLE)))
        else $error("Job taken from the queue without a result or a map pass.");

endmodule

@@ hw/rtl/contiguous_page_bitmap_allocator_unit.sv @@
// Top level of the first-fit contiguous page allocator.
// Depends on cpba_pkg, cpba_front, cpba_queue and cpba_back.
// A request is divided by the page size and classified, then popped from the queue;
// an alloc then scans the map one page a cycle and marks its run one page a cycle,
// and a free clears its run likewise. Throughput is set by the map scan of each
// alloc; results cannot be stalled. After reset busy stays high while the map
// is cleared.
module contiguous_page_bitmap_allocator_unit #(
    parameter int PAGES = cpba_pkg::PAGES_DEF,
    parameter int PAGE_BYTES = cpba_pkg::PAGE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cpba_pkg::cpba_req_t req,
    output logic                done,
    output cpba_pkg::cpba_rsp_t rsp
);
    import cpba_pkg::*;

    localparam int CNT_W = $clog2(PAGES + 1);
    localparam int JOB_W = 2 + PAGE_W + CNT_W;

    logic             front_busy;
    logic             clearing;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;

    assign busy = front_busy || clearing;

    cpba_front #(
        .PAGES(PAGES),
        .PAGE_BYTES(PAGE_BYTES),
        .CNT_W(CNT_W),
        .JOB_W(JOB_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start && !clearing),
        .busy(front_busy),
        .req(req),
        .push(push),
        .job(job_in),
        .full(full)
    );

    cpba_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .wdata(job_in),
        .pop(pop),
        .rdata(job_out),
        .full(full),
        .empty(empty)
    );

    cpba_back #(
        .PAGES(PAGES),
        .CNT_W(CNT_W),
        .JOB_W(JOB_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job(job_out),
        .empty(empty),
        .pop(pop),
        .clearing(clearing),
        .done(done),
        .rsp(rsp)
    );

endmodule
